### rtl/trd_pkg.sv
// Shared types, constants and result codes for the tape record deframer.
package trd_pkg;

  // Largest record, in 24-bit words, and the byte length that follows from it
  localparam int unsigned MAX_WORDS = 1024;
  localparam int unsigned MAX_LEN   = 3 * MAX_WORDS;
  localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1);

  // Divide by three as multiply by a rounded-up reciprocal, then shift
  localparam int unsigned DIV_K  = LEN_W + 2;
  localparam int unsigned DIV_M  = ((2 ** DIV_K) + 2) / 3;
  localparam int unsigned PROD_W = LEN_W + DIV_K;

  // Result kinds
  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_MARK   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_EOT        = 3'd1;
  localparam logic [2:0] ERR_LARGE      = 3'd2;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd3;
  localparam logic [2:0] ERR_FRAMING    = 3'd4;

  // Framing phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_DATA    = 4'b0010,
    PH_TRAILER = 4'b0100,
    PH_HALTED  = 4'b1000
  } phase_t;

  // One input item as held in the input register
  typedef struct packed {
    logic [7:0] tape_byte;
    logic       end_of_input;
  } item_t;

endpackage

### rtl/trd_ifs.sv
// Valid/ready channel interfaces for the deframer's input and result items.
interface trd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tape_byte;
  logic       end_of_input;

  modport source (output valid, output tape_byte, output end_of_input, input ready);
  modport sink   (input valid, input tape_byte, input end_of_input, output ready);
endinterface

interface trd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [23:0] data_word;
  logic [10:0] record_words;
  logic [2:0]  error_code;

  modport source (output valid, output result_kind, output data_word,
                  output record_words, output error_code, input ready);
  modport sink   (input valid, input result_kind, input data_word,
                  input record_words, input error_code, output ready);
endinterface

### rtl/trd_in_reg.sv
// Input register stage: captures one byte item and hands it to the framer.
module trd_in_reg
  import trd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  trd_in_if.sink   in_ch,
  output logic     item_valid,
  output item_t    item,
  input  logic     item_take
);

  logic  valid_r;
  item_t item_r;

  // Take a new item whenever the stage is empty or drains this cycle
  assign in_ch.ready = !valid_r || item_take;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.tape_byte    <= in_ch.tape_byte;
      item_r.end_of_input <= in_ch.end_of_input;
    end
  end

endmodule

### rtl/trd_core.sv
// Framing state machine, word packing and the registered result stage.
module trd_core
  import trd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_valid,
  input  item_t    item,
  output logic     item_take,
  trd_out_if.source out_ch
);

  phase_t           phase_r, phase_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [31:0]      hdr_r, hdr_nxt;
  logic [31:0]      trl_r, trl_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] words_r, words_nxt;
  logic [1:0]       rem_r, rem_nxt;
  logic [15:0]      held_r, held_nxt;
  logic [1:0]       biw_r, biw_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [23:0] word_r, word_nxt;
  logic [10:0] rwords_r, rwords_nxt;
  logic [2:0]  err_r, err_nxt;

  logic              fire;
  logic              emit;
  logic [31:0]       byte_sh;
  logic [31:0]       hdr_acc;
  logic [31:0]       trl_acc;
  logic [LEN_W-1:0]  len_lo;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  quot;
  logic [LEN_W:0]    quot3;
  logic [LEN_W:0]    len_minus;

  // Advance when the result register is free or being emptied
  assign fire      = item_valid && (!out_valid_r || out_ch.ready);
  assign item_take = fire;

  // Little-endian length assembly
  assign byte_sh = {24'd0, item.tape_byte} << {idx_r, 3'b000};
  assign hdr_acc = ((idx_r == 2'd0) ? 32'd0 : hdr_r) | byte_sh;
  assign trl_acc = trl_r | byte_sh;

  // Length / 3 and length % 3 for an accepted header
  assign len_lo    = hdr_acc[LEN_W-1:0];
  assign prod      = PROD_W'(len_lo) * PROD_W'(DIV_M);
  assign quot      = prod[PROD_W-1:DIV_K];
  assign quot3     = {quot, 1'b0} + {1'b0, quot};
  assign len_minus = {1'b0, len_lo} - quot3;

  // Per-item state update
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    hdr_nxt    = hdr_r;
    trl_nxt    = trl_r;
    left_nxt   = left_r;
    words_nxt  = words_r;
    rem_nxt    = rem_r;
    held_nxt   = held_r;
    biw_nxt    = biw_r;
    emit       = 1'b0;
    kind_nxt   = KIND_WORD;
    word_nxt   = 24'd0;
    rwords_nxt = 11'd0;
    err_nxt    = ERR_NONE;

    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (item.end_of_input) begin
            phase_nxt = PH_HALTED;
            emit      = 1'b1;
            kind_nxt  = KIND_ERROR;
            err_nxt   = ERR_EOT;
          end else begin
            hdr_nxt = hdr_acc;
            idx_nxt = idx_r + 2'd1;
            if (idx_r == 2'd3) begin
              if (hdr_acc == 32'd0) begin
                // zero length is a tape mark
                emit     = 1'b1;
                kind_nxt = KIND_MARK;
              end else if (hdr_acc > 32'(MAX_LEN)) begin
                phase_nxt = PH_HALTED;
                emit      = 1'b1;
                kind_nxt  = KIND_ERROR;
                err_nxt   = ERR_LARGE;
              end else begin
                phase_nxt = PH_DATA;
                left_nxt  = len_lo;
                words_nxt = quot;
                rem_nxt   = len_minus[1:0];
                held_nxt  = 16'd0;
                biw_nxt   = 2'd0;
              end
            end
          end
        end

        PH_DATA: begin
          if (item.end_of_input) begin
            phase_nxt = PH_HALTED;
            emit      = 1'b1;
            kind_nxt  = KIND_ERROR;
            err_nxt   = ERR_INCOMPLETE;
          end else begin
            // bytes past the last whole word are dropped
            if (left_r > LEN_W'(rem_r)) begin
              if (biw_r == 2'd2) begin
                emit     = 1'b1;
                kind_nxt = KIND_WORD;
                word_nxt = {held_r, item.tape_byte};
                held_nxt = 16'd0;
                biw_nxt  = 2'd0;
              end else begin
                held_nxt = {held_r[7:0], item.tape_byte};
                biw_nxt  = biw_r + 2'd1;
              end
            end
            left_nxt = left_r - LEN_W'(1);
            if (left_r == LEN_W'(1)) begin
              phase_nxt = PH_TRAILER;
              idx_nxt   = 2'd0;
              trl_nxt   = 32'd0;
            end
          end
        end

        PH_TRAILER: begin
          if (item.end_of_input) begin
            phase_nxt = PH_HALTED;
            emit      = 1'b1;
            kind_nxt  = KIND_ERROR;
            err_nxt   = ERR_FRAMING;
          end else begin
            trl_nxt = trl_acc;
            idx_nxt = idx_r + 2'd1;
            if (idx_r == 2'd3) begin
              emit = 1'b1;
              if (trl_acc != hdr_r) begin
                phase_nxt = PH_HALTED;
                kind_nxt  = KIND_ERROR;
                err_nxt   = ERR_FRAMING;
              end else begin
                phase_nxt  = PH_HEADER;
                kind_nxt   = KIND_RECORD;
                rwords_nxt = 11'(words_r);
              end
            end
          end
        end

        PH_HALTED: begin
          // silent until reset
        end

        default: begin
          phase_nxt = PH_HALTED;
        end
      endcase
    end
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      idx_r       <= 2'd0;
      hdr_r       <= 32'd0;
      trl_r       <= 32'd0;
      left_r      <= '0;
      words_r     <= '0;
      rem_r       <= 2'd0;
      held_r      <= 16'd0;
      biw_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      hdr_r       <= hdr_nxt;
      trl_r       <= trl_nxt;
      left_r      <= left_nxt;
      words_r     <= words_nxt;
      rem_r       <= rem_nxt;
      held_r      <= held_nxt;
      biw_r       <= biw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      kind_r   <= kind_nxt;
      word_r   <= word_nxt;
      rwords_r <= rwords_nxt;
      err_r    <= err_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = kind_r;
  assign out_ch.data_word    = word_r;
  assign out_ch.record_words = rwords_r;
  assign out_ch.error_code   = err_r;

endmodule

### rtl/tape_record_deframer_24bit.sv
// Tape-image record deframer top level: input register plus framing core.
//
// Takes one tape-image byte per item and accepts a new item every clock; an
// item's result, if any, is registered in the input register and then the
// result register, and the input keeps flowing while a result waits, stalling
// only when both the input register and the result register are full. Each
// record is a 4-byte little-endian length, the data bytes, and a 4-byte
// trailer that must repeat the length; data bytes come out packed big-endian
// as 24-bit words, a trailing 1 or 2 bytes are dropped, a zero length reports
// a tape mark, and a good trailer reports record complete with length / 3
// words. Lengths above 3 * MAX_WORDS, end of input at any point in the
// stream, or a mismatched trailer report an error, after which the block
// stays silent until reset. The one-item-per-cycle rate is set by the single
// state update between the input register and the result register.
module tape_record_deframer_24bit
  import trd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  trd_in_if.sink    in_ch,
  trd_out_if.source out_ch
);

  logic  item_valid;
  item_t item;
  logic  item_take;

  trd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  trd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_ch     (out_ch)
  );

endmodule

### rtl/trd_chk.sv
// Port-level checker for the deframer, bound to the top level.
module trd_chk
  import trd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic [23:0] out_data_word,
  input logic [10:0] out_record_words,
  input logic [2:0]  out_error_code
);

  logic halted_r;

  // Remember that an error item has been delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
    end else if (out_valid && out_ready && out_result_kind == KIND_ERROR) begin
      halted_r <= 1'b1;
    end
  end

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_data_word) && $stable(out_record_words) && $stable(out_error_code))
    else $error("result changed while stalled");

  // Nothing follows a delivered error
  assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !out_valid)
    else $error("result after error");

  // Fields outside the result kind are zero, and errors carry a real code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_result_kind == KIND_WORD) || out_data_word == 24'd0)
      && ((out_result_kind == KIND_RECORD) || out_record_words == 11'd0)
      && ((out_result_kind == KIND_ERROR) == (out_error_code != ERR_NONE))
      && (out_error_code == ERR_NONE || out_error_code == ERR_EOT
          || out_error_code == ERR_LARGE || out_error_code == ERR_INCOMPLETE
          || out_error_code == ERR_FRAMING))
    else $error("inconsistent result fields");

  // No result directly out of reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tape_record_deframer_24bit trd_chk u_trd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_kind  (out_ch.result_kind),
  .out_data_word    (out_ch.data_word),
  .out_record_words (out_ch.record_words),
  .out_error_code   (out_ch.error_code)
);

### sim/tb_tape_record_deframer_24bit.sv
// Self-checking testbench for the tape record deframer: framed records, marks and one error.
`timescale 1ns / 1ps

module tb_tape_record_deframer_24bit;
  import trd_pkg::*;

  // One result item as the deframer reports it
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] word;
    logic [10:0] words;
    logic [2:0]  err;
  } result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  trd_in_if  in_ch();
  trd_out_if out_ch();

  tape_record_deframer_24bit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  item_t   tape_bytes_q[$];
  result_t due_results[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fail_count    = 0;
  int bytes_taken   = 0;
  int words_seen    = 0;
  int records_seen  = 0;
  int marks_seen    = 0;
  int last_err_code = 0;

  // Predictor state
  phase_t      pr_phase;
  logic [1:0]  len_idx;
  logic [31:0] hdr_len;
  logic [31:0] trl_len;
  logic [11:0] left;
  logic [15:0] held;
  logic [1:0]  byte_pos;

  task automatic push_result(input logic [1:0] kind, input logic [23:0] word,
                             input logic [10:0] words, input logic [2:0] err);
    result_t r;
    r.kind  = kind;
    r.word  = word;
    r.words = words;
    r.err   = err;
    due_results.push_back(r);
  endtask

  task automatic halt_with(input logic [2:0] err);
    pr_phase = PH_HALTED;
    push_result(KIND_ERROR, '0, '0, err);
  endtask

  // Advance the framing state by one accepted byte and queue what it yields
  task automatic deframe_byte(input logic [7:0] b, input logic eoi);
    case (pr_phase)
      PH_HEADER: begin
        if (eoi) begin
          halt_with(ERR_EOT);
        end else begin
          if (len_idx == 2'd0) hdr_len = '0;
          hdr_len[8*len_idx +: 8] = b;
          len_idx = len_idx + 2'd1;
          if (len_idx == 2'd0) begin
            if (hdr_len == 32'd0) begin
              push_result(KIND_MARK, '0, '0, ERR_NONE);
            end else if (hdr_len > MAX_LEN) begin
              halt_with(ERR_LARGE);
            end else begin
              left     = hdr_len[11:0];
              byte_pos = 2'd0;
              held     = '0;
              pr_phase = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        if (eoi) begin
          halt_with(ERR_INCOMPLETE);
        end else begin
          // bytes past the last whole word are read and dropped
          if (left > hdr_len % 3) begin
            if (byte_pos == 2'd2) begin
              push_result(KIND_WORD, {held, b}, '0, ERR_NONE);
              byte_pos = 2'd0;
              held     = '0;
            end else begin
              held     = {held[7:0], b};
              byte_pos = byte_pos + 2'd1;
            end
          end
          if (left != 0) left = left - 12'd1;
          if (left == 0) begin
            pr_phase = PH_TRAILER;
            len_idx  = 2'd0;
            trl_len  = '0;
          end
        end
      end
      PH_TRAILER: begin
        if (eoi) begin
          halt_with(ERR_FRAMING);
        end else begin
          trl_len[8*len_idx +: 8] = b;
          len_idx = len_idx + 2'd1;
          if (len_idx == 2'd0) begin
            if (trl_len != hdr_len) begin
              halt_with(ERR_FRAMING);
            end else begin
              pr_phase = PH_HEADER;
              push_result(KIND_RECORD, '0, 11'(hdr_len / 3), ERR_NONE);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Driver: when the channel is free, offer the next queued item or, at random, go idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.tape_byte, in_ch.end_of_input);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tape_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item_t it;
          it = tape_bytes_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.tape_byte    <= it.tape_byte;
          in_ch.end_of_input <= it.end_of_input;
        end else begin
          in_ch.valid        <= 1'b0;
          in_ch.tape_byte    <= 8'($urandom_range(0, 255));
          in_ch.end_of_input <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d word %06h words %0d err %0d",
               out_ch.result_kind, out_ch.data_word, out_ch.record_words,
               out_ch.error_code);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (out_ch.result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_ch.result_kind);
          fail_count++;
        end
        if (out_ch.data_word !== want.word) begin
          $error("data_word: expected %06h, got %06h", want.word, out_ch.data_word);
          fail_count++;
        end
        if (out_ch.record_words !== want.words) begin
          $error("record_words: expected %0d, got %0d", want.words, out_ch.record_words);
          fail_count++;
        end
        if (out_ch.error_code !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, out_ch.error_code);
          fail_count++;
        end
        case (want.kind)
          KIND_WORD:   words_seen++;
          KIND_RECORD: records_seen++;
          KIND_MARK:   marks_seen++;
          default:     last_err_code = want.err;
        endcase
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Stimulus building blocks
  task automatic put_byte(input logic [7:0] b, input logic eoi);
    item_t it;
    it.tape_byte    = b;
    it.end_of_input = eoi;
    tape_bytes_q.push_back(it);
  endtask

  task automatic put_len(input logic [31:0] v);
    for (int i = 0; i < 4; i++) put_byte(v[8*i +: 8], 1'b0);
  endtask

  // fill < 0 means random data bytes
  task automatic put_data(input int n, input int fill);
    for (int i = 0; i < n; i++)
      put_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill), 1'b0);
  endtask

  task automatic put_record(input int n, input int fill);
    put_len(n);
    put_data(n, fill);
    put_len(n);
  endtask

  task automatic put_random_records(input int budget);
    int start;
    int r;
    start = tape_bytes_q.size();
    while (tape_bytes_q.size() - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 10)      put_len(0);
      else if (r < 75) put_record($urandom_range(1, 12), -1);
      else             put_record($urandom_range(13, 60), -1);
    end
  endtask

  // Ends the stream with one fault, then bytes the halted block must ignore
  task automatic put_fault_tail();
    int          n;
    int          k;
    logic [31:0] bad;
    case ($urandom_range(0, 4))
      0: begin
        // end of tape at the start of or part way into a header
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) put_byte(8'($urandom_range(0, 255)), 1'b0);
        put_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      1: begin
        // length over the limit, read unsigned
        case ($urandom_range(0, 2))
          0:       bad = MAX_LEN + 1;
          1:       bad = 32'hFFFF_FFFF;
          default: bad = {20'($urandom_range(1, 32'hF_FFFF)),
                          12'($urandom_range(0, 4095))};
        endcase
        put_len(bad);
      end
      2: begin
        // data cut short, possibly inside the dropped remainder
        n = $urandom_range(1, 20);
        k = $urandom_range(0, n - 1);
        put_len(n);
        put_data(k, -1);
        put_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      3: begin
        // trailer differs from header in one bit
        n = $urandom_range(1, 20);
        put_len(n);
        put_data(n, -1);
        put_len(n ^ (32'd1 << $urandom_range(0, 31)));
      end
      default: begin
        // trailer cut short
        n = $urandom_range(1, 20);
        k = $urandom_range(0, 3);
        put_len(n);
        put_data(n, -1);
        for (int i = 0; i < k; i++) put_byte(8'(n >> (8 * i)), 1'b0);
        put_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    for (int i = 0; i < 8; i++)
      put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Hold the sender until every queued byte is taken and every result is back
  task automatic drain();
    while (tape_bytes_q.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.tape_byte    = 8'h00;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    pr_phase = PH_HEADER;
    len_idx  = '0;
    hdr_len  = '0;
    trl_len  = '0;
    left     = '0;
    held     = '0;
    byte_pos = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      if (p == 0) begin
        // tape mark, all-ones word, single dropped byte of zero
        put_len(0);
        put_record(3, 8'hFF);
        put_record(1, 8'h00);
      end
      put_random_records(85);
      if (p == 3) put_fault_tail();
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d bytes: %0d words, %0d records, %0d tape marks,",
             bytes_taken, words_seen, records_seen, marks_seen);
    $display("ending on error code %0d with the halted block ignoring later bytes.",
             last_err_code);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/trd_pkg.sv
rtl/trd_ifs.sv
rtl/trd_in_reg.sv
rtl/trd_core.sv
rtl/tape_record_deframer_24bit.sv
rtl/trd_chk.sv
sim/tb_tape_record_deframer_24bit.sv
